[hw/rtl/mvs_pkg.sv]
`timescale 1ns / 1ps
package mvs_pkg;

   localparam int ROWS_DEF       = 4;
   localparam int BUCKETS_DEF    = 1024;
   localparam int MAX_HASHES_DEF = 4;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [2:0]  HPR_RESET = 3'd1;

   // Cell layout: {key, total, count}
   localparam int CELL_W = 160;

   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_FIN,
      ST_MOD,
      ST_READ,
      ST_CALC,
      ST_WRITE,
      ST_REDUCE,
      ST_RESP
   } state_type;

endpackage

[hw/rtl/majority_vote_sketch.sv]
`timescale 1ns / 1ps
// Update and query: per hash position, a byte-serial hash, a 4-bit-a-cycle
// bucket reduction, memory read, modify, write back, all rows in parallel; then the
// row minimums are folded row by row and the response register is loaded.
// Clear writes one entry of every row memory per cycle, through all BUCKETS entries.
// Throughput is one request at a time; the response register frees the next request.
// Reset (synchronous) runs the same clearing pass; no request is taken until it ends.
module majority_vote_sketch
   import mvs_pkg::*;
#(
   parameter int ROWS       = ROWS_DEF,
   parameter int BUCKETS    = BUCKETS_DEF,
   parameter int MAX_HASHES = MAX_HASHES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_flow_key,
   input  logic signed [31:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_estimate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);

   localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW = IW + 1;
   localparam int HW = $clog2(MAX_HASHES + 1);
   localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [RW-1:0] BMOD = RW'(BUCKETS);

   state_type state_ff, state_in;

   logic [2:0]    hpr_ff, hpr_in;
   logic [HW-1:0] nh;
   logic [HW-1:0] h_ff, h_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [RIW-1:0] row_ff, row_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_est_ff;

   logic [1:0]    cmd_ff;
   logic [31:0]   key_ff;
   logic [63:0]   amt_ff;
   logic [31:0]   est_ff;

   logic [31:0]   mix_ff  [ROWS];
   logic [31:0]   hsh_ff  [ROWS];
   logic [RW-1:0] rem_ff  [ROWS];
   logic [CELL_W-1:0] rdata_ff [ROWS];
   logic [63:0]   tot_ff  [ROWS];
   logic [63:0]   cnt_v_ff [ROWS];
   logic          match_ff [ROWS];
   logic [31:0]   rmin_ff [ROWS];

   logic accept, last_h, rsp_load, mem_we, csr_fire;

   function automatic logic [31:0] mix_key(input logic [31:0] k, input int r,
                                           input logic [HW-1:0] h);
      mix_key = (k + 32'(r)) * 32'd7 + 32'(r * 13) + 32'd31 * 32'(h);
   endfunction

   function automatic logic [31:0] byte_step(input logic [31:0] s, input logic [7:0] b);
      logic [31:0] t;
      t = s + {24'd0, b};
      t = t + (t << 10);
      byte_step = t ^ (t >> 6);
   endfunction

   function automatic logic [31:0] hash_fin(input logic [31:0] s);
      logic [31:0] t;
      t = s + (s << 3);
      t = t ^ (t >> 11);
      hash_fin = t + (t << 15);
   endfunction

   function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] r, input logic [3:0] bits);
      logic [RW-1:0] t;
      t = r;
      for (int i = 3; i >= 0; i--) begin
         t = {t[RW-2:0], bits[i]};
         if (t >= BMOD) begin
            t = t - BMOD;
         end
      end
      mod_step = t;
   endfunction

   assign nh       = ({1'b0, hpr_ff} > 4'(MAX_HASHES)) ? HW'(MAX_HASHES) : HW'(hpr_ff);
   assign accept   = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign last_h   = (h_ff + HW'(1)) >= nh;
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IW'(BUCKETS - 1)) begin
               state_in = (cmd_ff == CMD_CLEAR) ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_cmd == CMD_UPDATE || req_cmd == CMD_QUERY) begin
                  state_in = (nh == '0) ? ST_REDUCE : ST_HASH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_HASH:   state_in = (cnt_ff == 3'd3) ? ST_FIN : ST_HASH;
         ST_FIN:    state_in = ST_MOD;
         ST_MOD:    state_in = (cnt_ff == 3'd7) ? ST_READ : ST_MOD;
         ST_READ:   state_in = ST_CALC;
         ST_CALC:   state_in = ST_WRITE;
         ST_WRITE:  state_in = last_h ? ST_REDUCE : ST_HASH;
         ST_REDUCE: state_in = (row_ff == RIW'(ROWS - 1)) ? ST_RESP : ST_REDUCE;
         ST_RESP:   state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      mem_we    = (state_ff == ST_CLEAR) ||
                  ((state_ff == ST_WRITE) && (cmd_ff == CMD_UPDATE));
   end

   // control counters
   always_comb begin
      hpr_in       = csr_fire ? csr_data : hpr_ff;
      cnt_in       = (state_ff == ST_HASH || state_ff == ST_MOD) ? cnt_ff + 3'd1 : 3'd0;
      clr_in       = (state_ff == ST_CLEAR) ? clr_ff + IW'(1) : '0;
      row_in       = (state_ff == ST_REDUCE) ? row_ff + RIW'(1) : '0;
      h_in         = h_ff;
      if (accept) begin
         h_in = '0;
      end else if (state_ff == ST_WRITE) begin
         h_in = h_ff + HW'(1);
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hpr_ff       <= HPR_RESET;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         row_ff       <= '0;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_UPDATE;
      end else begin
         state_ff     <= state_in;
         hpr_ff       <= hpr_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cmd_ff <= req_cmd;
         end
      end
   end

   // hold the request and fold the row minimums
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_flow_key;
         amt_ff <= {{32{req_amount[31]}}, req_amount};
         est_ff <= ALL_ONES;
      end else if (state_ff == ST_REDUCE && rmin_ff[row_ff] < est_ff) begin
         est_ff <= rmin_ff[row_ff];
      end
      if (rsp_load) begin
         rsp_est_ff <= (cmd_ff == CMD_QUERY) ? est_ff : 32'd0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;

   // per-row lanes: hash, bucket reduction, row memory, read-modify-write
   for (genvar g = 0; g < ROWS; g++) begin : g_row
      logic [CELL_W-1:0] mem [BUCKETS];
      logic [IW-1:0]     addr;
      logic [CELL_W-1:0] wdata;
      logic [31:0]       half;
      logic [32:0]       adj;
      logic [31:0]       rkey;
      logic [63:0]       rtot, rcnt;

      assign rkey = rdata_ff[g][159:128];
      assign rtot = rdata_ff[g][127:64];
      assign rcnt = rdata_ff[g][63:0];
      assign addr = (state_ff == ST_CLEAR) ? clr_ff : rem_ff[g][IW-1:0];
      assign adj  = cnt_v_ff[g][32:0] + {32'd0, cnt_v_ff[g][63]};
      assign half = adj[32:1];

      // take the key on a negative count
      always_comb begin
         wdata = '0;
         if (state_ff != ST_CLEAR) begin
            if (!match_ff[g] && cnt_v_ff[g][63]) begin
               wdata = {key_ff, tot_ff[g], 64'd0 - cnt_v_ff[g]};
            end else begin
               wdata = {rkey, tot_ff[g], cnt_v_ff[g]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (mem_we) begin
            mem[addr] <= wdata;
         end
         if (state_ff == ST_READ) begin
            rdata_ff[g] <= mem[addr];
         end
      end

      always_ff @(posedge clock) begin
         // load the mixed key for the next position
         if (accept) begin
            mix_ff[g] <= mix_key(req_flow_key, g, '0);
         end else if (state_ff == ST_WRITE) begin
            mix_ff[g] <= mix_key(key_ff, g, h_ff + HW'(1));
         end
         if (accept || state_ff == ST_WRITE) begin
            hsh_ff[g] <= '0;
         end else if (state_ff == ST_HASH) begin
            hsh_ff[g] <= byte_step(hsh_ff[g], mix_ff[g][8*cnt_ff[1:0] +: 8]);
         end else if (state_ff == ST_FIN) begin
            hsh_ff[g] <= hash_fin(hsh_ff[g]);
         end
         if (state_ff == ST_FIN) begin
            rem_ff[g] <= '0;
         end else if (state_ff == ST_MOD) begin
            rem_ff[g] <= mod_step(rem_ff[g], hsh_ff[g][31 - 4*cnt_ff -: 4]);
         end
         if (state_ff == ST_CALC) begin
            match_ff[g] <= (rkey == key_ff);
            tot_ff[g]   <= rtot + amt_ff;
            if (cmd_ff == CMD_UPDATE) begin
               cnt_v_ff[g] <= (rkey == key_ff) ? rcnt + amt_ff : rcnt - amt_ff;
            end else begin
               cnt_v_ff[g] <= (rkey == key_ff) ? rtot + rcnt : rtot - rcnt;
            end
         end
         if (accept) begin
            rmin_ff[g] <= ALL_ONES;
         end else if (state_ff == ST_WRITE && cmd_ff == CMD_QUERY && half < rmin_ff[g]) begin
            rmin_ff[g] <= half;
         end
      end
   end

endmodule

[hw/rtl/mvs_checker.sv]
`timescale 1ns / 1ps
module mvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_estimate
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate))
      else $error("response changed while stalled");

   // block requests during the clearing pass after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // stay busy after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

endmodule

bind majority_vote_sketch mvs_checker u_mvs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_estimate (rsp_estimate)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import mvs_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CELLS = ROWS_DEF * BUCKETS_DEF;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int REPORT_MAX = 10;

   typedef enum logic [1:0] {E_REQ, E_CFG, E_DRAIN} entry_kind_t;

   typedef struct {
      entry_kind_t      kind;
      logic [1:0]       cmd;
      logic [31:0]      key;
      logic [31:0]      amt;
      logic [2:0]       hpr;
   } entry_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_UPDATE;
   logic [31:0] req_flow_key = '0;
   logic signed [31:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_estimate;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data = '0;

   majority_vote_sketch i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_flow_key(req_flow_key), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_estimate(rsp_estimate),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // sketch mirror
   logic [31:0] sk_key [CELLS];
   logic [63:0] sk_total [CELLS];
   logic [63:0] sk_count [CELLS];
   logic [2:0]  sk_hpr = HPR_RESET;

   entry_t      pending [$];
   logic [31:0] estimate_q [$];

   logic        req_taken = 1'b0;
   logic        csr_taken = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   int          hold_left = 0;
   bit          held_once = 0;
   int          n_rsp = 0;
   int          n_err = 0;
   int          n_update = 0, n_query = 0, n_clear = 0, n_cfg = 0;
   int          cycle_count = 0;
   logic [31:0] key_pool [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] oaat_hash(input logic [31:0] word);
      logic [31:0] hsh;
      hsh = '0;
      for (int b = 0; b < 4; b++) begin
         hsh += {24'd0, word[8*b +: 8]};
         hsh += hsh << 10;
         hsh ^= hsh >> 6;
      end
      hsh += hsh << 3;
      hsh ^= hsh >> 11;
      hsh += hsh << 15;
      return hsh;
   endfunction

   function automatic int bucket_of(input logic [31:0] key, input int row, input int pos);
      logic [31:0] mixed;
      mixed = (key + 32'(row)) * 32'd7 + 32'(row) * 32'd13 + 32'd31 * 32'(pos);
      return row * BUCKETS_DEF + int'(oaat_hash(mixed) % 32'(BUCKETS_DEF));
   endfunction

   // apply one request to the mirror and return its estimate
   task automatic sketch_apply(input logic [1:0] cmd, input logic [31:0] key,
                               input logic [31:0] amt, output logic [31:0] est);
      logic [63:0] amt64;
      logic signed [63:0] s;
      logic signed [63:0] q;
      int nh;
      int c;
      amt64 = {{32{amt[31]}}, amt};
      nh = (sk_hpr > MAX_HASHES_DEF) ? MAX_HASHES_DEF : int'(sk_hpr);
      est = '0;
      if (cmd == CMD_UPDATE) begin
         for (int r = 0; r < ROWS_DEF; r++)
            for (int h = 0; h < nh; h++) begin
               c = bucket_of(key, r, h);
               sk_total[c] += amt64;
               if (sk_key[c] == key) begin
                  sk_count[c] += amt64;
               end else begin
                  sk_count[c] -= amt64;
                  if (sk_count[c][63]) begin
                     sk_key[c] = key;
                     sk_count[c] = 64'd0 - sk_count[c];
                  end
               end
            end
      end else if (cmd == CMD_QUERY) begin
         est = ALL_ONES;
         for (int r = 0; r < ROWS_DEF; r++)
            for (int h = 0; h < nh; h++) begin
               c = bucket_of(key, r, h);
               s = (sk_key[c] == key) ? sk_total[c] + sk_count[c]
                                      : sk_total[c] - sk_count[c];
               q = s / 64'sd2;
               if (q[31:0] < est) est = q[31:0];
            end
      end else if (cmd == CMD_CLEAR) begin
         for (int i = 0; i < CELLS; i++) begin
            sk_key[i] = '0;
            sk_total[i] = '0;
            sk_count[i] = '0;
         end
      end
   endtask

   // predict on accepted requests and config writes, check responses
   always @(posedge clock) begin
      logic [31:0] est;
      logic [31:0] want;
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sk_hpr = csr_data;
            n_cfg++;
         end
         if (req_valid && req_ready) begin
            sketch_apply(req_cmd, req_flow_key, req_amount, est);
            estimate_q.push_back(est);
            case (req_cmd)
               CMD_UPDATE: n_update++;
               CMD_QUERY:  n_query++;
               CMD_CLEAR:  n_clear++;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (estimate_q.size() == 0) begin
               n_err++;
               if (n_err <= REPORT_MAX)
                  $display("response with nothing expected: estimate %h", rsp_estimate);
            end else begin
               want = estimate_q.pop_front();
               if (rsp_estimate !== want) begin
                  n_err++;
                  if (n_err <= REPORT_MAX)
                     $display("estimate mismatch at response %0d: expected %h, got %h",
                              n_rsp, want, rsp_estimate);
               end
            end
         end
      end
   end

   // request driver: bursts with gaps, drain and config points from the queue
   always @(negedge clock) begin
      entry_t it;
      logic   nv;
      logic   ncv;
      if (!reset && !(req_valid && !req_taken) && !(csr_valid && !csr_taken)) begin
         nv = 1'b0;
         ncv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() > 0) begin
            it = pending[0];
            if (it.kind == E_REQ) begin
               void'(pending.pop_front());
               req_cmd <= it.cmd;
               req_flow_key <= it.key;
               req_amount <= it.amt;
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               // wait out the block before a drain point or config write
               quiet_cycles = (estimate_q.size() == 0) ? quiet_cycles + 1 : 0;
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  void'(pending.pop_front());
                  quiet_cycles = 0;
                  if (it.kind == E_CFG) begin
                     csr_data <= it.hpr;
                     ncv = 1'b1;
                  end
               end
            end
         end
         req_valid <= nv;
         csr_valid <= ncv;
      end
   end

   // response side: changing stall pattern plus one long hold-off
   always @(negedge clock) begin
      if (!held_once && n_rsp >= 300) begin
         held_once = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((n_rsp / 150) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic entry_t make_req(input logic [1:0] cmd, input logic [31:0] key,
                                      input logic [31:0] amt);
      entry_t e;
      e.kind = E_REQ;
      e.cmd = cmd;
      e.key = key;
      e.amt = amt;
      e.hpr = '0;
      return e;
   endfunction

   function automatic entry_t make_cfg(input logic [2:0] hpr);
      entry_t e;
      e = make_req(CMD_UPDATE, '0, '0);
      e.kind = E_CFG;
      e.hpr = hpr;
      return e;
   endfunction

   function automatic entry_t make_drain();
      entry_t e;
      e = make_req(CMD_UPDATE, '0, '0);
      e.kind = E_DRAIN;
      return e;
   endfunction

   // random phase: mostly updates and queries on a small hot key set
   task automatic add_random(input int count);
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] amt;
      int          pick;
      for (int i = 0; i < 8; i++)
         key_pool[i] = (i == 0) ? 32'd0 : $urandom;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 199);
         if (pick < 110) cmd = CMD_UPDATE;
         else if (pick < 194) cmd = CMD_QUERY;
         else if (pick < 198) cmd = CMD_UNUSED;
         else cmd = CMD_CLEAR;
         key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
         pick = $urandom_range(0, 9);
         if (pick < 6) amt = 32'($signed($urandom_range(0, 400)) - 200);
         else if (pick < 8) amt = $urandom;
         else amt = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         pending.push_back(make_req(cmd, key, amt));
      end
   endtask

   initial begin
      // directed part at the reset setting of one hash per row
      pending.push_back(make_req(CMD_QUERY, 32'd0, 32'd0));
      pending.push_back(make_req(CMD_UPDATE, 32'd0, 32'd5));
      pending.push_back(make_req(CMD_QUERY, 32'd0, 32'hFFFF_FFFF));
      pending.push_back(make_req(CMD_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      pending.push_back(make_req(CMD_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      pending.push_back(make_req(CMD_QUERY, 32'hFFFF_FFFF, 32'd0));
      pending.push_back(make_req(CMD_UPDATE, 32'h1234_5678, 32'h8000_0000));
      pending.push_back(make_req(CMD_QUERY, 32'h1234_5678, 32'd0));
      pending.push_back(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending.push_back(make_req(CMD_CLEAR, 32'hA5A5_A5A5, 32'd1));
      pending.push_back(make_req(CMD_QUERY, 32'hFFFF_FFFF, 32'd0));
      pending.push_back(make_drain());
      // four positions, the most the block uses
      pending.push_back(make_cfg(3'd4));
      pending.push_back(make_req(CMD_UPDATE, 32'd77, 32'd10));
      pending.push_back(make_req(CMD_UPDATE, 32'd78, 32'd3));
      pending.push_back(make_req(CMD_QUERY, 32'd77, 32'd0));
      pending.push_back(make_req(CMD_QUERY, 32'd78, 32'd0));
      // no positions at all
      pending.push_back(make_cfg(3'd0));
      pending.push_back(make_req(CMD_UPDATE, 32'd77, 32'd100));
      pending.push_back(make_req(CMD_QUERY, 32'd77, 32'd0));
      // above the maximum acts as the maximum
      pending.push_back(make_cfg(3'd7));
      pending.push_back(make_req(CMD_UPDATE, 32'd77, 32'hFFFF_FF00));
      pending.push_back(make_req(CMD_QUERY, 32'd77, 32'd0));
      pending.push_back(make_req(CMD_QUERY, 32'd0, 32'd0));

      pending.push_back(make_cfg(3'd2));
      add_random(280);
      pending.push_back(make_drain());
      add_random(10);
      pending.push_back(make_cfg(3'd4));
      add_random(270);
      pending.push_back(make_cfg(3'd1));
      add_random(270);
      pending.push_back(make_cfg(3'd3));
      add_random(250);
      pending.push_back(make_cfg(3'd6));
      add_random(20);

      for (int i = 0; i < CELLS; i++) begin
         sk_key[i] = '0;
         sk_total[i] = '0;
         sk_count[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // hold for all requests to go out and every response to arrive
      while (pending.size() > 0 || req_valid || estimate_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d updates, %0d queries, %0d clears, %0d setting writes",
               n_update, n_query, n_clear, n_cfg);
      $display("%0d responses checked, %0d mismatches", n_rsp, n_err);
      if (n_err == 0 && estimate_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
